[rtl/core/ptrs_pkg.sv]
// Shared types and codes for the periodic task release scheduler.
// Holds the request and result structs, action, status and task state codes,
// and configuration register indexes and reset values. No dependencies.
package ptrs_pkg;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] name_key;
        logic [15:0] handler_id;
        logic [23:0] period_us;
        logic [1:0]  new_state;
    } ptrs_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        period_clamped;
        logic        task_valid;
        logic [15:0] task_handler;
        logic [31:0] task_name;
        logic        last;
    } ptrs_out_t;

    // Request actions.
    localparam logic [2:0] ACT_ADD       = 3'd0;
    localparam logic [2:0] ACT_REMOVE    = 3'd1;
    localparam logic [2:0] ACT_SET_STATE = 3'd2;
    localparam logic [2:0] ACT_TICK      = 3'd3;
    localparam logic [2:0] ACT_DISPATCH  = 3'd4;

    // Result status codes.
    localparam logic [2:0] RS_OK          = 3'd0;
    localparam logic [2:0] RS_FULL        = 3'd1;
    localparam logic [2:0] RS_DUP_NAME    = 3'd2;
    localparam logic [2:0] RS_DUP_HANDLER = 3'd3;
    localparam logic [2:0] RS_NOT_FOUND   = 3'd4;

    // Task states.
    localparam logic [1:0] TS_WAITING = 2'd0;
    localparam logic [1:0] TS_READY   = 2'd1;
    localparam logic [1:0] TS_BLOCKED = 2'd2;

    // Configuration register indexes and reset values.
    localparam logic [1:0]  REG_TICK_INC   = 2'd0;
    localparam logic [1:0]  REG_MIN_PERIOD = 2'd1;
    localparam logic [1:0]  REG_MAX_PERIOD = 2'd2;
    localparam logic [15:0] TICK_INC_RST   = 16'd10;
    localparam logic [23:0] MIN_PERIOD_RST = 24'd1000;
    localparam logic [23:0] MAX_PERIOD_RST = 24'd100000;

endpackage

[rtl/core/periodic_task_release_scheduler_core.sv]
// Periodic task release scheduler: task table, microsecond timer, sequencer
// and a shared bit-serial remainder unit. Depends on ptrs_pkg.
//
// One request is taken at a time; in_stall is low only while the sequencer
// is idle, and a finished result waits in the output register without
// holding off the next request. Add, remove and set state scan the table
// entry by entry and then load a result. A tick scans the table and, for
// each task that is neither ready nor blocked and has a nonzero period,
// finds the timer modulo period one quotient bit per cycle in a single
// shared 24-bit subtract-and-compare unit. A dispatch scans the entries up
// to and including the last ready task, giving one result per ready task
// (one result when nothing is ready), and holds while the output is stalled.
module periodic_task_release_scheduler_core
    import ptrs_pkg::*;
#(
    parameter int TASK_SLOTS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  ptrs_in_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output ptrs_out_t   out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CNT_W = $clog2(TASK_SLOTS + 1);
    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(TASK_SLOTS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ADD   = 3'd1;
    localparam logic [2:0] S_FIND  = 3'd2;
    localparam logic [2:0] S_TSCAN = 3'd3;
    localparam logic [2:0] S_TDIV  = 3'd4;
    localparam logic [2:0] S_DISP  = 3'd5;
    localparam logic [2:0] S_RESP  = 3'd6;

    // Control registers.
    logic [2:0]       fsm_reg, fsm_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      tick_time_reg, tick_time_next;
    logic             out_valid_reg, out_valid_next;
    logic [15:0]      tick_inc_reg;
    logic [23:0]      min_period_reg;
    logic [23:0]      max_period_reg;

    // Payload registers.
    ptrs_in_t         req_reg;
    logic [23:0]      add_period_reg;
    logic             clamp_reg, clamp_next;
    logic [2:0]       status_reg, status_next;
    logic [4:0]       bit_reg, bit_next;
    logic [23:0]      rem_reg, rem_next;
    ptrs_out_t        out_data_reg;

    // Task table.
    logic [31:0]      entry_name_reg    [TASK_SLOTS];
    logic [15:0]      entry_handler_reg [TASK_SLOTS];
    logic [23:0]      entry_period_reg  [TASK_SLOTS];
    logic [1:0]       entry_state_reg   [TASK_SLOTS];

    logic             in_accept;
    logic             out_free;
    logic             cfg_write;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] add_idx;
    logic [31:0]      cur_name;
    logic [15:0]      cur_handler;
    logic [23:0]      cur_period;
    logic [1:0]       cur_state;
    logic [TASK_SLOTS-1:0] ready_vec;
    logic [TASK_SLOTS-1:0] above_vec;
    logic             later_ready;
    logic [23:0]      clamp_period;
    logic             clamp_hit;
    logic [24:0]      trial;
    logic [24:0]      trial_diff;
    logic [23:0]      rem_step;
    logic             out_load;
    ptrs_out_t        out_load_data;
    logic             add_wr;
    logic             state_wr;
    logic [1:0]       state_wr_val;
    logic             shift_wr;

    assign in_stall  = (fsm_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    assign idx         = scan_reg[IDX_W-1:0];
    assign add_idx     = count_reg[IDX_W-1:0];
    assign cur_name    = entry_name_reg[idx];
    assign cur_handler = entry_handler_reg[idx];
    assign cur_period  = entry_period_reg[idx];
    assign cur_state   = entry_state_reg[idx];

    always_comb
    begin
        for (int j = 0; j < TASK_SLOTS; j++)
        begin
            ready_vec[j] = (entry_state_reg[j] == TS_READY) && (CNT_W'(j) < count_reg);
            above_vec[j] = (CNT_W'(j) > scan_reg);
        end
    end

    assign later_ready = |(ready_vec & above_vec);

    // Lower to the maximum first, then raise to the minimum.
    always_comb
    begin
        clamp_period = in_data.period_us;
        clamp_hit    = 1'b0;
        if (clamp_period > max_period_reg)
        begin
            clamp_period = max_period_reg;
            clamp_hit    = 1'b1;
        end
        if (clamp_period < min_period_reg)
        begin
            clamp_period = min_period_reg;
            clamp_hit    = 1'b1;
        end
    end

    // Shared remainder step: one quotient bit of timer modulo period a cycle.
    assign trial      = {rem_reg, tick_time_reg[bit_reg]};
    assign trial_diff = trial - {1'b0, cur_period};
    assign rem_step   = (trial >= {1'b0, cur_period}) ? trial_diff[23:0] : trial[23:0];

    always_comb
    begin
        fsm_next       = fsm_reg;
        scan_next      = scan_reg;
        count_next     = count_reg;
        tick_time_next = tick_time_reg;
        status_next    = status_reg;
        clamp_next     = clamp_reg;
        bit_next       = bit_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_load       = 1'b0;
        out_load_data  = '0;
        add_wr         = 1'b0;
        state_wr       = 1'b0;
        state_wr_val   = TS_WAITING;
        shift_wr       = 1'b0;

        unique case (fsm_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    scan_next   = '0;
                    status_next = RS_OK;
                    clamp_next  = 1'b0;
                    unique case (in_data.action) inside
                        ACT_ADD:
                        begin
                            if (count_reg >= SLOTS_CNT)
                            begin
                                status_next = RS_FULL;
                                fsm_next    = S_RESP;
                            end
                            else
                            begin
                                clamp_next = clamp_hit;
                                fsm_next   = S_ADD;
                            end
                        end
                        ACT_REMOVE, ACT_SET_STATE:
                        begin
                            fsm_next = S_FIND;
                        end
                        ACT_TICK:
                        begin
                            tick_time_next = tick_time_reg + 32'(tick_inc_reg);
                            fsm_next       = S_TSCAN;
                        end
                        ACT_DISPATCH:
                        begin
                            fsm_next = (|ready_vec) ? S_DISP : S_RESP;
                        end
                        default:
                        begin
                            fsm_next = S_RESP;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                if (scan_reg == count_reg)
                begin
                    add_wr     = 1'b1;
                    count_next = count_reg + 1'b1;
                    fsm_next   = S_RESP;
                end
                else if (cur_name == req_reg.name_key)
                begin
                    status_next = RS_DUP_NAME;
                    clamp_next  = 1'b0;
                    fsm_next    = S_RESP;
                end
                else if (cur_handler == req_reg.handler_id)
                begin
                    status_next = RS_DUP_HANDLER;
                    clamp_next  = 1'b0;
                    fsm_next    = S_RESP;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_FIND:
            begin
                if (scan_reg == count_reg)
                begin
                    status_next = RS_NOT_FOUND;
                    fsm_next    = S_RESP;
                end
                else if (cur_name == req_reg.name_key)
                begin
                    if (req_reg.action == ACT_REMOVE)
                    begin
                        shift_wr   = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        state_wr     = 1'b1;
                        state_wr_val = req_reg.new_state;
                    end
                    fsm_next = S_RESP;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_TSCAN:
            begin
                if (scan_reg == count_reg)
                begin
                    fsm_next = S_RESP;
                end
                else if (cur_state != TS_READY && cur_state != TS_BLOCKED &&
                         cur_period != 24'd0)
                begin
                    rem_next = '0;
                    bit_next = 5'd31;
                    fsm_next = S_TDIV;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_TDIV:
            begin
                rem_next = rem_step;
                if (bit_reg == 5'd0)
                begin
                    if (rem_step == 24'd0)
                    begin
                        state_wr     = 1'b1;
                        state_wr_val = TS_READY;
                    end
                    scan_next = scan_reg + 1'b1;
                    fsm_next  = S_TSCAN;
                end
                else
                begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            S_DISP:
            begin
                if (ready_vec[idx])
                begin
                    if (out_free)
                    begin
                        out_load                   = 1'b1;
                        out_load_data.status       = RS_OK;
                        out_load_data.task_valid   = 1'b1;
                        out_load_data.task_handler = cur_handler;
                        out_load_data.task_name    = cur_name;
                        out_load_data.last         = !later_ready;
                        state_wr                   = 1'b1;
                        state_wr_val               = TS_WAITING;
                        if (later_ready)
                        begin
                            scan_next = scan_reg + 1'b1;
                        end
                        else
                        begin
                            fsm_next = S_IDLE;
                        end
                    end
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_load                     = 1'b1;
                    out_load_data.status         = status_reg;
                    out_load_data.period_clamped = clamp_reg;
                    out_load_data.last           = 1'b1;
                    fsm_next                     = S_IDLE;
                end
            end
            default:
            begin
                fsm_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= S_IDLE;
            scan_reg      <= '0;
            count_reg     <= '0;
            tick_time_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fsm_reg       <= fsm_next;
            scan_reg      <= scan_next;
            count_reg     <= count_next;
            tick_time_reg <= tick_time_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg        <= in_data;
            add_period_reg <= clamp_period;
        end
        status_reg <= status_next;
        clamp_reg  <= clamp_next;
        bit_reg    <= bit_next;
        rem_reg    <= rem_next;
        if (out_load)
        begin
            out_data_reg <= out_load_data;
        end
    end

    // Table updates; removal shifts every entry above the match down by one.
    always_ff @(posedge clk)
    begin
        if (add_wr)
        begin
            entry_name_reg[add_idx]    <= req_reg.name_key;
            entry_handler_reg[add_idx] <= req_reg.handler_id;
            entry_period_reg[add_idx]  <= add_period_reg;
            entry_state_reg[add_idx]   <= req_reg.new_state;
        end
        if (state_wr)
        begin
            entry_state_reg[idx] <= state_wr_val;
        end
        if (shift_wr)
        begin
            for (int j = 0; j < TASK_SLOTS - 1; j++)
            begin
                if (CNT_W'(j) >= scan_reg && CNT_W'(j + 1) < count_reg)
                begin
                    entry_name_reg[j]    <= entry_name_reg[j + 1];
                    entry_handler_reg[j] <= entry_handler_reg[j + 1];
                    entry_period_reg[j]  <= entry_period_reg[j + 1];
                    entry_state_reg[j]   <= entry_state_reg[j + 1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_inc_reg   <= TICK_INC_RST;
            min_period_reg <= MIN_PERIOD_RST;
            max_period_reg <= MAX_PERIOD_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_TICK_INC:   tick_inc_reg   <= pwdata[15:0];
                REG_MIN_PERIOD: min_period_reg <= pwdata[23:0];
                REG_MAX_PERIOD: max_period_reg <= pwdata[23:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_TICK_INC:   prdata = {16'd0, tick_inc_reg};
            REG_MIN_PERIOD: prdata = {8'd0, min_period_reg};
            REG_MAX_PERIOD: prdata = {8'd0, max_period_reg};
            default:        prdata = '0;
        endcase
    end

endmodule

[verif/tb_periodic_task_release_scheduler_core.sv]
// Testbench for periodic_task_release_scheduler_core: task table add/remove/state requests,
// timer ticks and ready-task dispatch, checked against a shadow scheduler kept in this file.
// Depends on ptrs_pkg and the core RTL only.
module tb_periodic_task_release_scheduler_core;
    import ptrs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS          = 8;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 40;

    // Codes the package leaves unnamed.
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam logic [1:0] TS_SPARE     = 2'd3;

    typedef struct packed {
        ptrs_in_t   req;
        logic       typed;
        logic [2:0] status;
        logic       clamped;
    } plan_row_t;

    localparam int PLAN_ROWS = 26;
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        '{'{ACT_ADD, 32'h0, 16'h0, 24'h0, TS_WAITING}, 1'b1, RS_OK, 1'b1},
        '{'{ACT_ADD, 32'hFFFF_FFFF, 16'hFFFF, 24'hFF_FFFF, TS_READY}, 1'b1, RS_OK, 1'b1},
        '{'{ACT_ADD, 32'd1, 16'd1, 24'd5000, TS_WAITING}, 1'b1, RS_OK, 1'b0},
        '{'{ACT_ADD, 32'd0, 16'd7, 24'd5000, TS_WAITING}, 1'b1, RS_DUP_NAME, 1'b0},
        '{'{ACT_ADD, 32'd9, 16'hFFFF, 24'd5000, TS_WAITING}, 1'b1, RS_DUP_HANDLER, 1'b0},
        // Entry 0's handler matches before entry 1's name is reached.
        '{'{ACT_ADD, 32'hFFFF_FFFF, 16'd0, 24'd5000, TS_WAITING}, 1'b1, RS_DUP_HANDLER, 1'b0},
        '{'{ACT_ADD, 32'd2, 16'd2, 24'd1000, TS_BLOCKED}, 1'b1, RS_OK, 1'b0},
        '{'{ACT_ADD, 32'd3, 16'd3, 24'd100000, TS_SPARE}, 1'b1, RS_OK, 1'b0},
        '{'{ACT_ADD, 32'd4, 16'd4, 24'd999, TS_WAITING}, 1'b1, RS_OK, 1'b1},
        '{'{ACT_ADD, 32'd5, 16'd5, 24'd100001, TS_WAITING}, 1'b1, RS_OK, 1'b1},
        '{'{ACT_ADD, 32'd6, 16'd6, 24'd20000, TS_WAITING}, 1'b1, RS_OK, 1'b0},
        '{'{ACT_ADD, 32'd7, 16'd7, 24'd20000, TS_WAITING}, 1'b1, RS_FULL, 1'b0},
        '{'{ACT_REMOVE, 32'h55, 16'h0, 24'h0, TS_WAITING}, 1'b1, RS_NOT_FOUND, 1'b0},
        '{'{ACT_SET_STATE, 32'h55, 16'h0, 24'h0, TS_READY}, 1'b1, RS_NOT_FOUND, 1'b0},
        '{'{ACT_DISPATCH, 32'h0, 16'h0, 24'h0, TS_WAITING}, 1'b0, RS_OK, 1'b0},
        '{'{ACT_DISPATCH, 32'h0, 16'h0, 24'h0, TS_WAITING}, 1'b0, RS_OK, 1'b0},
        '{'{ACT_SET_STATE, 32'd1, 16'h0, 24'h0, TS_READY}, 1'b1, RS_OK, 1'b0},
        '{'{ACT_SET_STATE, 32'd0, 16'h0, 24'h0, TS_READY}, 1'b1, RS_OK, 1'b0},
        '{'{ACT_SET_STATE, 32'd3, 16'h0, 24'h0, TS_SPARE}, 1'b1, RS_OK, 1'b0},
        '{'{ACT_DISPATCH, 32'h0, 16'h0, 24'h0, TS_WAITING}, 1'b0, RS_OK, 1'b0},
        '{'{ACT_REMOVE, 32'd0, 16'h0, 24'h0, TS_WAITING}, 1'b1, RS_OK, 1'b0},
        '{'{ACT_TICK, 32'h0, 16'h0, 24'h0, TS_WAITING}, 1'b1, RS_OK, 1'b0},
        '{'{ACT_SPARE_LO, 32'hFFFF_FFFF, 16'hFFFF, 24'hFF_FFFF, TS_SPARE}, 1'b1, RS_OK, 1'b0},
        '{'{ACT_SPARE_HI, 32'hFFFF_FFFF, 16'hFFFF, 24'hFF_FFFF, TS_SPARE}, 1'b1, RS_OK, 1'b0},
        '{'{ACT_REMOVE, 32'd6, 16'h0, 24'h0, TS_WAITING}, 1'b1, RS_OK, 1'b0},
        '{'{ACT_DISPATCH, 32'h0, 16'h0, 24'h0, TS_WAITING}, 1'b0, RS_OK, 1'b0}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    ptrs_in_t    in_data;
    logic        out_valid;
    logic        out_stall;
    ptrs_out_t   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Shadow scheduler: configuration, timer and task table.
    logic [15:0] cfg_tick;
    logic [23:0] cfg_min;
    logic [23:0] cfg_max;
    logic [31:0] sh_time;
    int          sh_count;
    logic [31:0] sh_name    [SLOTS];
    logic [15:0] sh_handler [SLOTS];
    logic [23:0] sh_period  [SLOTS];
    logic [1:0]  sh_state   [SLOTS];

    ptrs_out_t   step_results[$];
    ptrs_out_t   due_results[$];
    ptrs_out_t   want;

    bit          calm;
    int          errors;
    int          requests_sent;
    int          results_seen;
    int          settings_used;
    int          timer_wraps;
    int          multi_dispatches;
    int          quiet_cycles;

    periodic_task_release_scheduler_core #(
        .TASK_SLOTS (SLOTS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    task automatic post_result(input logic [2:0] st, input logic cl, input logic vld,
                               input logic [15:0] hnd, input logic [31:0] nm,
                               input logic lst);
        ptrs_out_t r;
        r.status         = st;
        r.period_clamped = cl;
        r.task_valid     = vld;
        r.task_handler   = hnd;
        r.task_name      = nm;
        r.last           = lst;
        step_results.push_back(r);
    endtask

    function automatic int locate_task(input logic [31:0] nm);
        int hit;
        hit = -1;
        for (int i = sh_count - 1; i >= 0; i--)
        begin
            if (sh_name[i] == nm)
                hit = i;
        end
        return hit;
    endfunction

    // Applies one request to the shadow table and leaves its results in step_results.
    task automatic advance_scheduler(input ptrs_in_t req);
        logic [2:0]  st;
        logic        cl;
        logic [23:0] per;
        logic [31:0] prev;
        int          hit;
        int          n;
        st   = RS_OK;
        cl   = 1'b0;
        per  = req.period_us;
        prev = sh_time;
        n    = 0;
        step_results.delete();
        case (req.action)
            ACT_ADD:
            begin
                if (sh_count >= SLOTS)
                    st = RS_FULL;
                for (int i = 0; i < sh_count && st == RS_OK; i++)
                begin
                    if (sh_name[i] == req.name_key)
                        st = RS_DUP_NAME;
                    else if (sh_handler[i] == req.handler_id)
                        st = RS_DUP_HANDLER;
                end
                if (st == RS_OK)
                begin
                    // Lowered to the maximum first, so an inverted range ends at the minimum.
                    if (per > cfg_max)
                    begin
                        per = cfg_max;
                        cl  = 1'b1;
                    end
                    if (per < cfg_min)
                    begin
                        per = cfg_min;
                        cl  = 1'b1;
                    end
                    sh_name[sh_count]    = req.name_key;
                    sh_handler[sh_count] = req.handler_id;
                    sh_period[sh_count]  = per;
                    sh_state[sh_count]   = req.new_state;
                    sh_count++;
                end
                post_result(st, cl, 1'b0, 16'h0, 32'h0, 1'b1);
            end
            ACT_REMOVE, ACT_SET_STATE:
            begin
                hit = locate_task(req.name_key);
                if (hit < 0)
                    post_result(RS_NOT_FOUND, 1'b0, 1'b0, 16'h0, 32'h0, 1'b1);
                else
                begin
                    if (req.action == ACT_SET_STATE)
                        sh_state[hit] = req.new_state;
                    else
                    begin
                        for (int i = hit; i + 1 < sh_count; i++)
                        begin
                            sh_name[i]    = sh_name[i + 1];
                            sh_handler[i] = sh_handler[i + 1];
                            sh_period[i]  = sh_period[i + 1];
                            sh_state[i]   = sh_state[i + 1];
                        end
                        sh_count--;
                    end
                    post_result(RS_OK, 1'b0, 1'b0, 16'h0, 32'h0, 1'b1);
                end
            end
            ACT_TICK:
            begin
                sh_time = sh_time + 32'(cfg_tick);
                if (sh_time < prev)
                    timer_wraps++;
                // A zero period never releases; the spare state is released like waiting.
                for (int i = 0; i < sh_count; i++)
                begin
                    if (sh_state[i] != TS_BLOCKED && sh_state[i] != TS_READY &&
                        sh_period[i] != 24'h0 && (sh_time % 32'(sh_period[i])) == 32'h0)
                        sh_state[i] = TS_READY;
                end
                post_result(RS_OK, 1'b0, 1'b0, 16'h0, 32'h0, 1'b1);
            end
            ACT_DISPATCH:
            begin
                for (int i = 0; i < sh_count; i++)
                begin
                    if (sh_state[i] == TS_READY)
                    begin
                        post_result(RS_OK, 1'b0, 1'b1, sh_handler[i], sh_name[i], 1'b0);
                        sh_state[i] = TS_WAITING;
                        n++;
                    end
                end
                if (n == 0)
                    post_result(RS_OK, 1'b0, 1'b0, 16'h0, 32'h0, 1'b1);
                else
                    step_results[n - 1].last = 1'b1;
                if (n > 1)
                    multi_dispatches++;
            end
            default:
            begin
                post_result(RS_OK, 1'b0, 1'b0, 16'h0, 32'h0, 1'b1);
            end
        endcase
    endtask

    // Presents one request, waits for it to be taken and files the expected results.
    task automatic issue_request(input ptrs_in_t req, input logic typed,
                                 input logic [2:0] st, input logic cl);
        ptrs_out_t fixed;
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (in_stall);
        advance_scheduler(req);
        requests_sent++;
        if (typed)
        begin
            fixed                = '0;
            fixed.status         = st;
            fixed.period_clamped = cl;
            fixed.last           = 1'b1;
            due_results.push_back(fixed);
        end
        else
        begin
            foreach (step_results[i])
                due_results.push_back(step_results[i]);
        end
        if (!calm && $urandom_range(0, 99) < 15)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
    endtask

    task automatic set_regs(input logic [15:0] tick, input logic [23:0] lo,
                            input logic [23:0] hi);
        write_reg(REG_TICK_INC, {16'h0, tick});
        write_reg(REG_MIN_PERIOD, {8'h0, lo});
        write_reg(REG_MAX_PERIOD, {8'h0, hi});
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        cfg_tick = tick;
        cfg_min  = lo;
        cfg_max  = hi;
        settings_used++;
    endtask

    function automatic logic [31:0] pick_name(input bit known);
        if (known && sh_count > 0 && $urandom_range(0, 3) != 0)
            return sh_name[$urandom_range(0, sh_count - 1)];
        if ($urandom_range(0, 6) == 0)
            return $urandom();
        return 32'($urandom_range(0, 11));
    endfunction

    // Mostly table traffic over a small pool of names and handlers, so that
    // duplicates, removals and releases happen often; some full-range noise.
    function automatic ptrs_in_t pick_request(input int unsigned span);
        ptrs_in_t    r;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 24)
            r.action = ACT_ADD;
        else if (roll < 36)
            r.action = ACT_REMOVE;
        else if (roll < 48)
            r.action = ACT_SET_STATE;
        else if (roll < 78)
            r.action = ACT_TICK;
        else if (roll < 96)
            r.action = ACT_DISPATCH;
        else
            r.action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        r.name_key   = pick_name(r.action != ACT_ADD);
        r.handler_id = ($urandom_range(0, 4) == 0) ? 16'($urandom())
                                                    : 16'($urandom_range(0, 11));
        r.period_us  = ($urandom_range(0, 4) == 0) ? 24'($urandom())
                                                    : 24'($urandom_range(0, span));
        if ($urandom_range(0, 9) == 0)
            r.new_state = TS_SPARE;
        else if (r.action == ACT_SET_STATE && $urandom_range(0, 1) == 0)
            r.new_state = TS_READY;
        else
            r.new_state = 2'($urandom_range(TS_WAITING, TS_BLOCKED));
        return r;
    endfunction

    task automatic run_random(input int count, input int unsigned span,
                              input int calm_from, input int calm_to);
        for (int k = 0; k < count; k++)
        begin
            calm = (k >= calm_from && k < calm_to);
            // Once per phase the sender holds off until the block has drained.
            if (k == count / 2)
            begin
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (due_results.size() != 0);
            end
            issue_request(pick_request(span), 1'b0, RS_OK, 1'b0);
        end
        calm = 1'b0;
    endtask

    task automatic compare_field(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, what, exp_v, got_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
            begin
                $display("%0t: result with nothing expected, got %p", $time, out_data);
                errors++;
            end
            else
            begin
                want = due_results.pop_front();
                compare_field("status", 32'(want.status), 32'(out_data.status));
                compare_field("period_clamped", 32'(want.period_clamped),
                              32'(out_data.period_clamped));
                compare_field("task_valid", 32'(want.task_valid), 32'(out_data.task_valid));
                compare_field("task_handler", 32'(want.task_handler),
                              32'(out_data.task_handler));
                compare_field("task_name", want.task_name, out_data.task_name);
                compare_field("last", 32'(want.last), 32'(out_data.last));
                results_seen++;
            end
        end
        out_stall <= !calm && ($urandom_range(0, 99) < 15);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no request or result moved for %0d cycles", $time, quiet_cycles);
            $display("tb_periodic_task_release_scheduler_core: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        ptrs_in_t        req;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_stall <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        cfg_tick  = TICK_INC_RST;
        cfg_min   = MIN_PERIOD_RST;
        cfg_max   = MAX_PERIOD_RST;
        sh_time   = 32'h0;
        sh_count  = 0;
        calm      = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < PLAN_ROWS; r++)
            issue_request(PLAN[r].req, PLAN[r].typed, PLAN[r].status, PLAN[r].clamped);

        // Short periods and a unit tick: tasks are released every few ticks.
        settle();
        set_regs(16'd1, 24'd1, 24'd64);
        run_random(60, 80, 15, 45);

        // Largest tick and a zero minimum period, starting from an emptied table,
        // so that zero periods get stored and must never release.
        settle();
        set_regs(16'hFFFF, 24'h0, 24'hFF_FFFF);
        calm = 1'b1;
        while (sh_count > 0)
        begin
            req          = '0;
            req.action   = ACT_REMOVE;
            req.name_key = sh_name[0];
            issue_request(req, 1'b0, RS_OK, 1'b0);
        end
        calm = 1'b0;
        run_random(40, 8, 0, 0);

        // Minimum above maximum: every added period ends at the minimum.
        settle();
        set_regs(16'd3, 24'd6, 24'd2);
        run_random(30, 10, 0, 0);

        settle();
        set_regs(16'd1, 24'hFF_FFFF, 24'd1);
        run_random(15, 10, 0, 0);
        settle();

        $display("Ran %0d requests over %0d register settings; %0d results compared.",
                 requests_sent, settings_used, results_seen);
        $display("Timer wrapped %0d time(s); %0d dispatches released several tasks.",
                 timer_wraps, multi_dispatches);
        if (errors == 0)
            $display("tb_periodic_task_release_scheduler_core: done, clean");
        else
            $display("tb_periodic_task_release_scheduler_core: done, errors");
        $finish;
    end

endmodule
